[src/assert_macros.svh]
// Assertion helpers used by the checker of this block.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TPC_ASSERT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("tpc assertion failed");

// Next-cycle implication.
`define TPC_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("tpc assertion failed");

`endif

[src/tpc_pkg.sv]
`default_nettype none

package tpc_pkg;

  localparam int unsigned TIME_BITS    = 32;
  localparam int unsigned CMP_BITS     = 16;
  localparam int unsigned PCT_BITS     = 8;
  localparam int unsigned FUNC_BITS    = 3;
  localparam int unsigned LEVEL_BITS   = 7;

  localparam int unsigned PCT_LOW      = 1;
  localparam int unsigned PCT_HIGH     = 100;
  localparam int unsigned PCT_SPAN     = PCT_HIGH - PCT_LOW;

  localparam logic [CMP_BITS-1:0] DUTY_MIN_RESET = CMP_BITS'(600);
  localparam logic [CMP_BITS-1:0] DUTY_MAX_RESET = CMP_BITS'(1200);

  // Divide by PCT_SPAN through a scaled reciprocal; exact for level * span < 2^23.
  localparam int unsigned      RECIP_SHIFT = 30;
  localparam longint unsigned  RECIP_M     = ((64'd1 << RECIP_SHIFT) + PCT_SPAN - 1) / PCT_SPAN;
  localparam int unsigned      RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned      PROD_W      = CMP_BITS + RECIP_W;

  typedef logic [RECIP_W-1:0] recip_tbl_t [PCT_HIGH];

  function automatic recip_tbl_t build_recip_tbl();
    recip_tbl_t tbl;
    for (int i = 0; i < PCT_HIGH; i++) begin
      tbl[i] = RECIP_W'(longint'(i) * RECIP_M);
    end
    return tbl;
  endfunction

  localparam recip_tbl_t RECIP_TBL = build_recip_tbl();

  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned REG_SEL_BIT = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_TICK        = 3'd0,
    FUNC_START       = 3'd1,
    FUNC_TIMED_START = 3'd2,
    FUNC_STOP        = 3'd3,
    FUNC_PAUSE       = 3'd4,
    FUNC_RESUME      = 3'd5
  } func_e;

  typedef enum logic {
    REG_DUTY_MIN = 1'b0,
    REG_DUTY_MAX = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [FUNC_BITS-1:0] func;
    logic [PCT_BITS-1:0]  percent;
    logic [TIME_BITS-1:0] duration_ms;
  } cmd_t;

  typedef struct packed {
    logic [CMP_BITS-1:0]  pwm_compare;
    logic                 pwm_on;
    logic                 is_running;
    logic                 is_timed;
    logic                 is_paused;
    logic                 valve_out;
    logic [TIME_BITS-1:0] remaining_ms;
  } res_t;

  typedef struct packed {
    logic [CMP_BITS-1:0] duty_min;
    logic [CMP_BITS-1:0] duty_max;
  } cfg_t;

endpackage

`default_nettype wire

[src/tpc_if.sv]
`default_nettype none

interface tpc_cmd_if import tpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FUNC_BITS-1:0] func;
  logic [PCT_BITS-1:0]  percent;
  logic [TIME_BITS-1:0] duration_ms;

  modport source (output valid, func, percent, duration_ms, input ready);
  modport sink   (input valid, func, percent, duration_ms, output ready);
endinterface

interface tpc_res_if import tpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMP_BITS-1:0]  pwm_compare;
  logic                 pwm_on;
  logic                 is_running;
  logic                 is_timed;
  logic                 is_paused;
  logic                 valve_out;
  logic [TIME_BITS-1:0] remaining_ms;

  modport source (output valid, pwm_compare, pwm_on, is_running, is_timed, is_paused,
                  valve_out, remaining_ms, input ready);
  modport sink   (input valid, pwm_compare, pwm_on, is_running, is_timed, is_paused,
                  valve_out, remaining_ms, output ready);
endinterface

`default_nettype wire

[src/timed_pwm_pump_controller.sv]
// Channel  | Dir | Handshake        | Payload
// ---------+-----+------------------+-----------------------------------------------
// cmd_i    | in  | valid/ready      | func, percent, duration_ms
// res_o    | out | valid/ready      | pwm_compare, pwm_on, is_running, is_timed,
//          |     |                  | is_paused, valve_out, remaining_ms
// APB      | in  | psel/penable     | paddr, pwdata (write), prdata (read)
//
// Each command yields one result, held first in the input register and then in
// the result register. A new command is taken every cycle unless back-pressure on
// res_o stalls it. The rate is set by the single update path between the two registers.
// rst_ni is asynchronous, active low; it clears all pump state and loads the duty
// registers with 600 and 1200. Back-pressure on res_o holds the result and, once
// the input register is also full, drops cmd_i.ready.
`default_nettype none

module timed_pwm_pump_controller import tpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tpc_cmd_if.sink           cmd_i,
  tpc_res_if.source         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cmd_t cmd;
  res_t res;

  // Duty range registers; the user writes only with no command in flight, not enforced.
  tpc_apb_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Pack the command transfer.
  assign cmd.func        = cmd_i.func;
  assign cmd.percent     = cmd_i.percent;
  assign cmd.duration_ms = cmd_i.duration_ms;

  // Input register, state update and result register.
  tpc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .in_cmd_i   (cmd),
    .out_valid_o(res_o.valid),
    .out_ready_i(res_o.ready),
    .out_res_o  (res)
  );

  // Unpack the result transfer.
  assign res_o.pwm_compare  = res.pwm_compare;
  assign res_o.pwm_on       = res.pwm_on;
  assign res_o.is_running   = res.is_running;
  assign res_o.is_timed     = res.is_timed;
  assign res_o.is_paused    = res.is_paused;
  assign res_o.valve_out    = res.valve_out;
  assign res_o.remaining_ms = res.remaining_ms;

endmodule

`default_nettype wire

[src/tpc_duty_map.sv]
`default_nettype none

module tpc_duty_map import tpc_pkg::*; (
  input  cfg_t                cfg_i,
  input  logic [PCT_BITS-1:0] percent_i,
  output logic [CMP_BITS-1:0] duty_o
);

  logic [LEVEL_BITS-1:0] level;
  logic                  rising;
  logic [CMP_BITS-1:0]   span;
  logic [PROD_W-1:0]     prod;
  logic [CMP_BITS-1:0]   step;

  // Clamp to 1..100, then use the zero-based level as table index.
  always_comb begin
    if (percent_i < PCT_BITS'(PCT_LOW)) begin
      level = '0;
    end else if (percent_i > PCT_BITS'(PCT_HIGH)) begin
      level = LEVEL_BITS'(PCT_SPAN);
    end else begin
      level = LEVEL_BITS'(percent_i - PCT_BITS'(PCT_LOW));
    end
  end

  assign rising = (cfg_i.duty_max >= cfg_i.duty_min);
  assign span   = rising ? (cfg_i.duty_max - cfg_i.duty_min)
                         : (cfg_i.duty_min - cfg_i.duty_max);

  // level * span / 99 as span * (level * reciprocal) >> shift.
  assign prod = PROD_W'(span) * PROD_W'(RECIP_TBL[level]);
  assign step = prod[RECIP_SHIFT +: CMP_BITS];

  assign duty_o = rising ? (cfg_i.duty_min + step) : (cfg_i.duty_min - step);

endmodule

`default_nettype wire

[src/tpc_core.sv]
`default_nettype none

module tpc_core import tpc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  cmd_t in_cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  typedef struct packed {
    logic                 run;
    logic                 timed;
    logic                 pause;
    logic                 oe;
    logic                 valve;
    logic [CMP_BITS-1:0]  duty;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] run_len;
  } state_t;

  localparam state_t HALT_STATE = '{run: 1'b0, timed: 1'b0, pause: 1'b0, oe: 1'b0,
                                    valve: 1'b1, duty: '0, elapsed: '0, run_len: '0};

  logic                 in_vld_q;
  cmd_t                 in_cmd_q;
  logic                 out_vld_q;
  res_t                 out_res_q;
  state_t               st_q, st_d;
  res_t                 res_d;
  logic                 adv;
  logic                 active;
  logic [TIME_BITS-1:0] tick_cnt;
  logic [CMP_BITS-1:0]  mapped_duty;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  tpc_duty_map u_map (
    .cfg_i    (cfg_i),
    .percent_i(in_cmd_q.percent),
    .duty_o   (mapped_duty)
  );

  assign active   = st_q.run && st_q.timed;
  assign tick_cnt = (st_q.elapsed == '1) ? st_q.elapsed : st_q.elapsed + 1'b1;

  always_comb begin
    st_d = st_q;
    case (func_e'(in_cmd_q.func))
      FUNC_TICK: begin
        if (active && !st_q.pause) begin
          st_d.elapsed = tick_cnt;
          if (tick_cnt >= st_q.run_len) begin
            st_d = HALT_STATE;
          end
        end
      end
      FUNC_START: begin
        st_d.valve = 1'b0;
        st_d.duty  = mapped_duty;
        st_d.oe    = 1'b1;
        st_d.run   = 1'b1;
      end
      FUNC_TIMED_START: begin
        st_d.valve   = 1'b0;
        st_d.duty    = mapped_duty;
        st_d.oe      = 1'b1;
        st_d.run     = 1'b1;
        st_d.run_len = in_cmd_q.duration_ms;
        st_d.elapsed = '0;
        st_d.timed   = 1'b1;
      end
      FUNC_STOP: begin
        st_d = HALT_STATE;
      end
      FUNC_PAUSE: begin
        st_d.pause = 1'b1;
        if (active) begin
          st_d.oe = 1'b0;
        end
      end
      FUNC_RESUME: begin
        st_d.pause = 1'b0;
        if (active) begin
          st_d.oe = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_d.pwm_compare  = st_d.oe ? st_d.duty : '0;
    res_d.pwm_on       = st_d.oe;
    res_d.is_running   = st_d.run;
    res_d.is_timed     = st_d.timed;
    res_d.is_paused    = st_d.pause;
    res_d.valve_out    = st_d.valve;
    res_d.remaining_ms = (st_d.timed && (st_d.run_len > st_d.elapsed))
                         ? (st_d.run_len - st_d.elapsed) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
        st_q      <= st_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_cmd_q <= in_cmd_i;
    end
    if (adv) begin
      out_res_q <= res_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_res_q;

endmodule

`default_nettype wire

[src/tpc_apb_regs.sv]
`default_nettype none

module tpc_apb_regs import tpc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[REG_SEL_BIT]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duty_min <= DUTY_MIN_RESET;
      cfg_q.duty_max <= DUTY_MAX_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_DUTY_MIN: cfg_q.duty_min <= pwdata[CMP_BITS-1:0];
        REG_DUTY_MAX: cfg_q.duty_max <= pwdata[CMP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DUTY_MIN: prdata = APB_DW'(cfg_q.duty_min);
      REG_DUTY_MAX: prdata = APB_DW'(cfg_q.duty_max);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[src/tpc_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module tpc_checker import tpc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [CMP_BITS-1:0]  pwm_compare_i,
  input logic                 pwm_on_i,
  input logic                 is_running_i,
  input logic                 is_timed_i,
  input logic                 is_paused_i,
  input logic                 valve_out_i,
  input logic [TIME_BITS-1:0] remaining_ms_i
);

  logic [CMP_BITS+TIME_BITS+4:0] res_bits;

  assign res_bits = {pwm_compare_i, pwm_on_i, is_running_i, is_timed_i, is_paused_i,
                     valve_out_i, remaining_ms_i};

  `TPC_ASSERT(a_off_zero, out_valid_i && !pwm_on_i, pwm_compare_i == '0)
  `TPC_ASSERT(a_on_running, out_valid_i && (pwm_on_i || is_timed_i), is_running_i)
  `TPC_ASSERT(a_valve_stopped, out_valid_i && valve_out_i, !is_running_i)
  `TPC_ASSERT(a_untimed_rem, out_valid_i && !is_timed_i, remaining_ms_i == '0)
  `TPC_ASSERT_NEXT(a_res_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(res_bits))

endmodule

bind timed_pwm_pump_controller tpc_checker u_tpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .pwm_compare_i (res_o.pwm_compare),
  .pwm_on_i      (res_o.pwm_on),
  .is_running_i  (res_o.is_running),
  .is_timed_i    (res_o.is_timed),
  .is_paused_i   (res_o.is_paused),
  .valve_out_i   (res_o.valve_out),
  .remaining_ms_i(res_o.remaining_ms)
);

`default_nettype wire
